FILE: rtl/multitone_bin_average_generator_macros.svh
// assertion macros for the multitone bin average generator checker
// each macro expects clk and rst_n in the scope where it is used
`ifndef MULTITONE_BIN_AVERAGE_GENERATOR_MACROS_SVH
`define MULTITONE_BIN_AVERAGE_GENERATOR_MACROS_SVH

// same-cycle implication, skipped while reset is held
`define MTBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, skipped while reset is held
`define MTBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mtba_pkg.sv
// shared constants, register codes and types of the multitone bin average generator
// no dependencies
`timescale 1ns / 1ps

package mtba_pkg;

    // sizing defaults
    localparam int MAX_TONES            = 5;
    localparam int TONE_COUNT_DEF       = 5;
    localparam int SINE_TABLE_DEPTH_DEF = 1024;
    localparam int OUT_FIFO_DEPTH       = 8;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_TONE_A       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TONE_B       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TONE_C       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TONE_D       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TONE_E       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 3'd5;

    localparam logic [31:0] SAMPLE_COUNT_RST = 32'd1024;

    // datapath widths
    localparam int PHASE_W     = 32;
    localparam int COEF_W      = 32;
    localparam int SINE_W      = 17;   // stored magnitude, Q0.17 without sign
    localparam int SSINE_W     = 18;   // signed sine
    localparam int DIFF_W      = 19;
    localparam int PROD_W      = COEF_W + DIFF_W;
    localparam int ROUND_SHIFT = 17;
    localparam int TERM_W      = PROD_W - ROUND_SHIFT;
    localparam int PART_W      = TERM_W + 1;
    localparam int SUM_W       = TERM_W + 2;
    localparam int OUT_W       = 32;

    // table generation: pi/2 in Q2.30 and full-scale sine
    localparam longint unsigned HPI_Q30  = 64'd1686629713;
    localparam longint unsigned SINE_MAX = 64'd131071;

    // rounding and saturation
    localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(65536);
    localparam logic signed [SUM_W-1:0]  SUM_MAX    = SUM_W'(64'sh7FFFFFFF);
    localparam logic signed [SUM_W-1:0]  SUM_MIN    = SUM_W'(-64'sh80000000);
    localparam logic signed [OUT_W-1:0]  OUT_MAX    = 32'sh7FFFFFFF;
    localparam logic signed [OUT_W-1:0]  OUT_MIN    = 32'sh80000000;

    // per-stage control that travels with a sample
    typedef struct packed {
        logic valid;
        logic last;
    } lane_ctl_t;

    // one finished output word
    typedef struct packed {
        logic signed [OUT_W-1:0] sample_value;
        logic                    frame_end;
        logic                    clipped;
    } out_word_t;

endpackage

FILE: rtl/multitone_bin_average_generator.sv
// multitone bin average generator: one sample per advance word, sum of tone sine steps
// path: phase, sine read, difference, product, rounding, partial-sum registers, output queue
// throughput: one word per cycle while in_stall is low; an 8-entry output queue keeps input
// open while out stalls, until its credits are used; reset: tones clear, sample_count 1024;
// then the sine tables load with in_stall high; configuration writes are taken meanwhile
`timescale 1ns / 1ps

module multitone_bin_average_generator #(
    parameter int TONE_COUNT       = mtba_pkg::TONE_COUNT_DEF,
    parameter int SINE_TABLE_DEPTH = mtba_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic                                    advance,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [mtba_pkg::OUT_W-1:0]       sample_value,
    output logic                                    frame_end,
    output logic                                    clipped,
    input  logic                                    cfg_write,
    input  logic [mtba_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [mtba_pkg::CFG_DATA_W-1:0]         cfg_data
);

    localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam logic [AW-1:0] DEPTH_A = AW'(SINE_TABLE_DEPTH);
    localparam int IW = $clog2(mtba_pkg::OUT_FIFO_DEPTH + 1);
    localparam logic [IW-1:0] CREDITS = IW'(mtba_pkg::OUT_FIFO_DEPTH);

    typedef logic [mtba_pkg::SINE_W-1:0] sine_rom_t [SINE_TABLE_DEPTH+1];

    // quarter-wave table: Taylor series through x^11 in Q2.30, rounded to Q0.17
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t       rom;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned r;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++)
        begin
            x    = (mtba_pkg::HPI_Q30 * 64'(i)) / SINE_TABLE_DEPTH;
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            term = ((term * x2) >> 30) / 64'd6;
            sum  = (sum >= term) ? sum - term : 64'd0;
            term = ((term * x2) >> 30) / 64'd20;
            sum  = sum + term;
            term = ((term * x2) >> 30) / 64'd42;
            sum  = (sum >= term) ? sum - term : 64'd0;
            term = ((term * x2) >> 30) / 64'd72;
            sum  = sum + term;
            term = ((term * x2) >> 30) / 64'd110;
            sum  = (sum >= term) ? sum - term : 64'd0;
            r    = (sum + 64'd4096) >> 13;
            if (r > mtba_pkg::SINE_MAX)
            begin
                r = mtba_pkg::SINE_MAX;
            end
            rom[i] = mtba_pkg::SINE_W'(r);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    logic [63:0]                             tone_reg [mtba_pkg::MAX_TONES];
    logic [31:0]                             sample_count_reg;
    logic                                    filling_reg;
    logic [AW-1:0]                           fill_addr_reg;
    logic [mtba_pkg::SINE_W-1:0]             fill_data;
    logic [IW-1:0]                           inflight_reg;
    logic [IW-1:0]                           inflight_next;
    logic                                    tick;
    logic                                    out_take;
    logic [31:0]                             sample_index_reg;
    logic [31:0]                             last_index;
    logic                                    at_end;
    mtba_pkg::lane_ctl_t                     ctl1_reg;
    mtba_pkg::lane_ctl_t                     ctl2_reg;
    mtba_pkg::lane_ctl_t                     ctl3_reg;
    mtba_pkg::lane_ctl_t                     ctl4_reg;
    mtba_pkg::lane_ctl_t                     ctl5_reg;
    mtba_pkg::lane_ctl_t                     ctl6_reg;
    logic signed [mtba_pkg::TERM_W-1:0]      term [mtba_pkg::MAX_TONES];
    logic signed [mtba_pkg::PART_W-1:0]      part_a_reg;
    logic signed [mtba_pkg::PART_W-1:0]      part_b_reg;
    logic signed [mtba_pkg::PART_W-1:0]      part_c_reg;
    logic signed [mtba_pkg::SUM_W-1:0]       total;
    mtba_pkg::out_word_t                     push_word;
    mtba_pkg::out_word_t                     head_word;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < mtba_pkg::MAX_TONES; t++)
            begin
                tone_reg[t] <= '0;
            end
            sample_count_reg <= mtba_pkg::SAMPLE_COUNT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mtba_pkg::REG_TONE_A:       tone_reg[0] <= cfg_data;
                mtba_pkg::REG_TONE_B:       tone_reg[1] <= cfg_data;
                mtba_pkg::REG_TONE_C:       tone_reg[2] <= cfg_data;
                mtba_pkg::REG_TONE_D:       tone_reg[3] <= cfg_data;
                mtba_pkg::REG_TONE_E:       tone_reg[4] <= cfg_data;
                mtba_pkg::REG_SAMPLE_COUNT: sample_count_reg <= cfg_data[31:0];
                default:                    ;
            endcase
        end
    end

    // sine table load sweep after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filling_reg   <= 1'b1;
            fill_addr_reg <= '0;
        end
        else if (filling_reg)
        begin
            if (fill_addr_reg == DEPTH_A)
            begin
                filling_reg <= 1'b0;
            end
            else
            begin
                fill_addr_reg <= fill_addr_reg + AW'(1);
            end
        end
    end

    assign fill_data = SINE_ROM[fill_addr_reg];

    // input handshake and credits for the output queue
    assign in_stall = filling_reg || (inflight_reg == CREDITS);
    assign tick     = in_valid && !in_stall && advance;
    assign out_take = out_valid && !out_stall;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (tick && !out_take)
        begin
            inflight_next = inflight_reg + IW'(1);
        end
        else if (out_take && !tick)
        begin
            inflight_next = inflight_reg - IW'(1);
        end
    end

    // frame position
    assign last_index = (sample_count_reg == '0) ? '0 : sample_count_reg - 32'd1;
    assign at_end     = (sample_index_reg >= last_index);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg     <= '0;
            sample_index_reg <= '0;
            ctl1_reg         <= '0;
            ctl2_reg         <= '0;
            ctl3_reg         <= '0;
            ctl4_reg         <= '0;
            ctl5_reg         <= '0;
            ctl6_reg         <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
            if (tick)
            begin
                sample_index_reg <= at_end ? '0 : sample_index_reg + 32'd1;
            end
            ctl1_reg.valid <= tick;
            ctl1_reg.last  <= at_end;
            ctl2_reg       <= ctl1_reg;
            ctl3_reg       <= ctl2_reg;
            ctl4_reg       <= ctl3_reg;
            ctl5_reg       <= ctl4_reg;
            ctl6_reg       <= ctl5_reg;
        end
    end

    // tone lanes: phase accumulator here, lookup and scaling in the lane
    for (genvar j = 0; j < mtba_pkg::MAX_TONES; j++)
    begin : g_tone
        if (j < TONE_COUNT)
        begin : g_on
            logic [mtba_pkg::PHASE_W-1:0] phase_acc_reg;
            logic [mtba_pkg::PHASE_W-1:0] phase_next;
            logic [mtba_pkg::PHASE_W-1:0] phase1_reg;

            assign phase_next = phase_acc_reg + tone_reg[j][31:0];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    phase_acc_reg <= '0;
                end
                else if (tick)
                begin
                    phase_acc_reg <= at_end ? '0 : phase_next;
                end
            end

            always_ff @(posedge clk)
            begin
                phase1_reg <= phase_next;
            end

            mtba_tone_lane #(
                .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
            ) u_lane (
                .clk       (clk),
                .rst_n     (rst_n),
                .fill_we   (filling_reg),
                .fill_addr (fill_addr_reg),
                .fill_data (fill_data),
                .phase     (phase1_reg),
                .ctl_rd    (ctl2_reg),
                .coef      ($signed(tone_reg[j][63:32])),
                .term      (term[j])
            );
        end
        else
        begin : g_off
            assign term[j] = '0;
        end
    end

    // partial sums of the five terms
    always_ff @(posedge clk)
    begin
        part_a_reg <= mtba_pkg::PART_W'(term[0]) + mtba_pkg::PART_W'(term[1]);
        part_b_reg <= mtba_pkg::PART_W'(term[2]) + mtba_pkg::PART_W'(term[3]);
        part_c_reg <= mtba_pkg::PART_W'(term[4]);
    end

    // final sum and saturation to 32 bits
    always_comb
    begin
        total = mtba_pkg::SUM_W'(part_a_reg) + mtba_pkg::SUM_W'(part_b_reg)
              + mtba_pkg::SUM_W'(part_c_reg);
        push_word.frame_end = ctl6_reg.last;
        if (total > mtba_pkg::SUM_MAX)
        begin
            push_word.sample_value = mtba_pkg::OUT_MAX;
            push_word.clipped      = 1'b1;
        end
        else if (total < mtba_pkg::SUM_MIN)
        begin
            push_word.sample_value = mtba_pkg::OUT_MIN;
            push_word.clipped      = 1'b1;
        end
        else
        begin
            push_word.sample_value = total[mtba_pkg::OUT_W-1:0];
            push_word.clipped      = 1'b0;
        end
    end

    mtba_out_fifo #(
        .DEPTH (mtba_pkg::OUT_FIFO_DEPTH)
    ) u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (ctl6_reg.valid),
        .push_word  (push_word),
        .pop        (out_take),
        .head_word  (head_word),
        .head_valid (out_valid)
    );

    assign sample_value = head_word.sample_value;
    assign frame_end    = head_word.frame_end;
    assign clipped      = head_word.clipped;

endmodule

FILE: rtl/mtba_sine_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module mtba_sine_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1025
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/mtba_tone_lane.sv
// one tone lane: quarter-wave lookup, sine difference, coefficient multiply, rounding
// depends on mtba_pkg and mtba_sine_ram
`timescale 1ns / 1ps

module mtba_tone_lane #(
    parameter int SINE_TABLE_DEPTH = mtba_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       fill_we,
    input  logic [$clog2(SINE_TABLE_DEPTH+1)-1:0]      fill_addr,
    input  logic [mtba_pkg::SINE_W-1:0]                fill_data,
    input  logic [mtba_pkg::PHASE_W-1:0]               phase,
    input  mtba_pkg::lane_ctl_t                        ctl_rd,
    input  logic signed [mtba_pkg::COEF_W-1:0]         coef,
    output logic signed [mtba_pkg::TERM_W-1:0]         term
);

    localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int MW = 30 + AW;
    localparam logic [AW-1:0] DEPTH_A = AW'(SINE_TABLE_DEPTH);

    logic [MW-1:0]                          scaled;
    logic [AW-1:0]                          k;
    logic [AW-1:0]                          rd_addr;
    logic [mtba_pkg::SINE_W-1:0]            mag;
    logic                                   neg_reg;
    logic signed [mtba_pkg::SSINE_W-1:0]    sine_next;
    logic signed [mtba_pkg::SSINE_W-1:0]    prev_sine_reg;
    logic signed [mtba_pkg::DIFF_W-1:0]     diff_next;
    logic signed [mtba_pkg::DIFF_W-1:0]     diff_reg;
    logic signed [mtba_pkg::PROD_W-1:0]     prod_next;
    logic signed [mtba_pkg::PROD_W-1:0]     prod_reg;
    logic signed [mtba_pkg::PROD_W-1:0]     rounded;
    logic signed [mtba_pkg::TERM_W-1:0]     term_reg;

    // table index from the fractional quadrant phase, mirrored in odd quadrants
    always_comb
    begin
        scaled  = MW'(phase[29:0]) * MW'(DEPTH_A);
        k       = scaled[MW-1:30];
        rd_addr = phase[30] ? (DEPTH_A - k) : k;
    end

    mtba_sine_ram #(
        .WIDTH (mtba_pkg::SINE_W),
        .DEPTH (SINE_TABLE_DEPTH + 1)
    ) u_sine_ram (
        .clk   (clk),
        .we    (fill_we),
        .waddr (fill_addr),
        .wdata (fill_data),
        .raddr (rd_addr),
        .rdata (mag)
    );

    // sign follows the table read
    always_ff @(posedge clk)
    begin
        neg_reg <= phase[31];
    end

    // signed sine and difference against the previous sample of this tone
    always_comb
    begin
        sine_next = neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        diff_next = mtba_pkg::DIFF_W'(sine_next) - mtba_pkg::DIFF_W'(prev_sine_reg);
    end

    // previous sine is cleared by the last sample of a frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sine_reg <= '0;
        end
        else if (ctl_rd.valid)
        begin
            prev_sine_reg <= ctl_rd.last ? '0 : sine_next;
        end
    end

    // coefficient times difference, then round Q3.46 to Q2.29 half up
    always_comb
    begin
        prod_next = mtba_pkg::PROD_W'(coef) * mtba_pkg::PROD_W'(diff_reg);
        rounded   = prod_reg + mtba_pkg::ROUND_BIAS;
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
        prod_reg <= prod_next;
        term_reg <= rounded[mtba_pkg::PROD_W-1:mtba_pkg::ROUND_SHIFT];
    end

    assign term = term_reg;

endmodule

FILE: rtl/mtba_out_fifo.sv
// small output queue that decouples the datapath from the output stall
// depends on mtba_pkg
`timescale 1ns / 1ps

module mtba_out_fifo #(
    parameter int DEPTH = mtba_pkg::OUT_FIFO_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  mtba_pkg::out_word_t  push_word,
    input  logic                 pop,
    output mtba_pkg::out_word_t  head_word,
    output logic                 head_valid
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

    mtba_pkg::out_word_t slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

    assign head_word  = slot_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);

endmodule

FILE: rtl/mtba_checker.sv
// port-level checker for the multitone bin average generator, bound to the top level
// depends on multitone_bin_average_generator_macros.svh and mtba_pkg
`timescale 1ns / 1ps
`include "multitone_bin_average_generator_macros.svh"

module mtba_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_stall,
    input logic                               advance,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic signed [mtba_pkg::OUT_W-1:0]  sample_value,
    input logic                               frame_end,
    input logic                               clipped
);

    logic [7:0] pending_reg;
    logic       tick;
    logic       out_take;

    // words requested but not yet delivered
    assign tick     = in_valid && !in_stall && advance;
    assign out_take = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (tick && !out_take)
        begin
            pending_reg <= pending_reg + 8'd1;
        end
        else if (out_take && !tick)
        begin
            pending_reg <= pending_reg - 8'd1;
        end
    end

    // a stalled output word holds
    `MTBA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(sample_value) && $stable(frame_end) && $stable(clipped), "output word changed under stall")

    // a clipped sample sits at one of the rails
    `MTBA_ASSERT_NOW(a_clip_rail, out_valid && clipped, sample_value == mtba_pkg::OUT_MAX || sample_value == mtba_pkg::OUT_MIN, "clipped sample not at a rail")

    // no output word without an advance waiting for it
    `MTBA_ASSERT_NOW(a_no_extra_word, out_valid, pending_reg != 8'd0, "output word without a pending advance")

endmodule

bind multitone_bin_average_generator mtba_checker u_mtba_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .advance      (advance),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample_value (sample_value),
    .frame_end    (frame_end),
    .clipped      (clipped)
);

FILE: bench/testbench.sv
// self-checking bench for the multitone bin average generator: scoreboard class and drivers
// depends on rtl/mtba_pkg.sv and rtl/multitone_bin_average_generator.sv
`timescale 1ns / 1ps

module testbench;

    import mtba_pkg::*;

    localparam int WORD_TARGET = 450;    // input words accepted over the whole run
    localparam int DRAIN_PAD   = 16;     // pipeline depth plus margin
    localparam int STALL_LIMIT = 4000;   // covers the sine table load after reset
    localparam int PRINT_CAP   = 40;

    // indexes that map to no register
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    // scoreboard: tone synthesis predictor plus queue of expected sample words
    class tone_sample_scoreboard;
        logic [63:0] tone_reg [MAX_TONES];
        logic [31:0] frame_len;
        logic [31:0] phase_acc [MAX_TONES];
        int          prev_sine [MAX_TONES];
        logic [31:0] sample_idx;
        int          sine_rom [0:SINE_TABLE_DEPTH_DEF];
        out_word_t   expected_samples [$];
        int          ticks;
        int          frame_ends;
        int          saturated;
        int          errors;

        function new();
            longint unsigned x, x2, term, acc;
            // quarter-wave table, taylor series through x^11 in Q2.30
            for (int i = 0; i <= SINE_TABLE_DEPTH_DEF; i++)
            begin
                x = (HPI_Q30 * longint'(i)) / longint'(SINE_TABLE_DEPTH_DEF);
                x2 = (x * x) >> 30;
                term = x;
                acc = x;
                for (int n = 1; n <= 5; n++)
                begin
                    term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
                    if (n % 2 == 1)
                        acc = (acc >= term) ? acc - term : 0;
                    else
                        acc = acc + term;
                end
                acc = (acc + 4096) >> 13;
                if (acc > SINE_MAX)
                    acc = SINE_MAX;
                sine_rom[i] = int'(acc);
            end
            for (int j = 0; j < MAX_TONES; j++)
                tone_reg[j] = '0;
            frame_len = SAMPLE_COUNT_RST;
            clear_frame();
            ticks = 0;
            frame_ends = 0;
            saturated = 0;
            errors = 0;
        endfunction

        function void clear_frame();
            for (int j = 0; j < MAX_TONES; j++)
            begin
                phase_acc[j] = '0;
                prev_sine[j] = 0;
            end
            sample_idx = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_TONE_A, REG_TONE_B, REG_TONE_C, REG_TONE_D, REG_TONE_E:
                    tone_reg[idx] = data;
                REG_SAMPLE_COUNT:
                    frame_len = data[31:0];
                default:
                    ;
            endcase
        endfunction

        // quadrant folding of the quarter-wave table
        function int sine_at(logic [31:0] phase);
            longint unsigned k;
            int v;
            k = (longint'(phase[29:0]) * longint'(SINE_TABLE_DEPTH_DEF)) >> 30;
            if (k > SINE_TABLE_DEPTH_DEF)
                k = SINE_TABLE_DEPTH_DEF;
            v = phase[30] ? sine_rom[SINE_TABLE_DEPTH_DEF - int'(k)] : sine_rom[int'(k)];
            return phase[31] ? -v : v;
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction

        // one advance word: step every tone and queue the summed sample
        function void note_advance();
            longint    total, coef, prod;
            int        s;
            logic [31:0] final_idx;
            out_word_t w;
            total = 0;
            for (int j = 0; j < TONE_COUNT_DEF; j++)
            begin
                phase_acc[j] = phase_acc[j] + tone_reg[j][31:0];
                s = sine_at(phase_acc[j]);
                coef = longint'($signed(tone_reg[j][63:32]));
                prod = coef * longint'(s - prev_sine[j]);
                total = total + ((prod + 64'sd65536) >>> 17);
                prev_sine[j] = s;
            end
            w.clipped = 1'b0;
            if (total > 64'sh7FFFFFFF)
            begin
                w.sample_value = OUT_MAX;
                w.clipped = 1'b1;
            end
            else if (total < -64'sh80000000)
            begin
                w.sample_value = OUT_MIN;
                w.clipped = 1'b1;
            end
            else
                w.sample_value = total[31:0];
            final_idx = (frame_len == 0) ? 32'd0 : frame_len - 1;
            w.frame_end = (sample_idx >= final_idx);
            if (w.frame_end)
                clear_frame();
            else
                sample_idx = sample_idx + 1;
            expected_samples.push_back(w);
            ticks++;
        endfunction

        task report(string msg);
            if (errors < PRINT_CAP)
                $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_sample(logic signed [31:0] value, logic fe, logic cl);
            out_word_t w;
            if (expected_samples.size() == 0)
            begin
                report($sformatf("unexpected sample %0d", value));
                return;
            end
            w = expected_samples.pop_front();
            if (value !== w.sample_value)
                report($sformatf("sample_value %0d, want %0d", value, w.sample_value));
            if (fe !== w.frame_end)
                report($sformatf("frame_end %b, want %b", fe, w.frame_end));
            if (cl !== w.clipped)
                report($sformatf("clipped %b, want %b", cl, w.clipped));
            if (w.frame_end)
                frame_ends++;
            if (w.clipped)
                saturated++;
        endtask
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic                        advance = 1'b0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic signed [OUT_W-1:0]     sample_value;
    logic                        frame_end;
    logic                        clipped;
    logic                        cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index = '0;
    logic [CFG_DATA_W-1:0]       cfg_data = '0;

    tone_sample_scoreboard sb;
    int idle_words = 0;
    int setting_count = 0;
    int quiet_cycles = 0;
    int stall_mode = 0;
    int stall_span = 0;

    multitone_bin_average_generator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .advance      (advance),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample_value (sample_value),
        .frame_end    (frame_end),
        .clipped      (clipped),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // receiver stall pattern: a random mode held for a random span
    always @(negedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_span <= $urandom_range(16, 96);
        end
        else
            stall_span <= stall_span - 1;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 7) != 0);
            default: out_stall <= ~out_stall;
        endcase
    end

    // monitor: note accepted words, check results, watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_sample(sample_value, frame_end, clipped);
            if (in_valid && !in_stall)
            begin
                if (advance)
                    sb.note_advance();
                else
                    idle_words++;
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic send_word(input logic adv);
        @(negedge clk);
        in_valid <= 1'b1;
        advance <= adv;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // bursts of random length with random gaps, some bursts back to back
    task automatic send_words(input int count, input int idle_pct);
        int burst_left;
        int gap;
        burst_left = 0;
        for (int i = 0; i < count; i++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0)
                begin
                    @(negedge clk);
                    in_valid <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
            end
            burst_left--;
            send_word(($urandom_range(0, 99) < idle_pct) ? 1'b0 : 1'b1);
        end
    endtask

    // wait until every expected sample is back and the pipeline is empty
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_PAD) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        sb.set_reg(idx, data);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [63:0] pick_tone();
        logic [31:0] coef_bits;
        logic [31:0] step_bits;
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0: coef_bits = 32'h7FFFFFFF;
            1: coef_bits = 32'h80000000;
            2: coef_bits = 32'h00000000;
            3, 4: coef_bits = $urandom;
            default: coef_bits = {{10{r[21]}}, r[21:0]};
        endcase
        case ($urandom_range(0, 9))
            0: step_bits = 32'h00000000;
            1: step_bits = 32'hFFFFFFFF;
            2: step_bits = 32'h40000000;
            3: step_bits = 32'h80000000;
            4, 5: step_bits = $urandom;
            default: step_bits = $urandom_range(0, 32'h00FFFFFF);
        endcase
        return {coef_bits, step_bits};
    endfunction

    function automatic logic [63:0] pick_count();
        logic [31:0] n;
        case ($urandom_range(0, 9))
            0: n = 32'd0;
            1: n = 32'd1;
            2: n = 32'hFFFFFFFF;
            default: n = $urandom_range(2, 48);
        endcase
        return {$urandom, n};
    endfunction

    // stimulus
    initial
    begin
        sb = new();
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: silent tones, long frame
        send_word(1'b1);
        send_word(1'b0);
        send_word(1'b1);
        send_word(1'b1);
        setting_count++;

        // full-scale tones driving both saturation limits, short frame
        settle();
        write_reg(REG_TONE_A, {32'h7FFFFFFF, 32'h40000000});
        write_reg(REG_TONE_B, {32'h7FFFFFFF, 32'h40000000});
        write_reg(REG_TONE_C, {32'h00000000, 32'hFFFFFFFF});
        write_reg(REG_TONE_D, {32'h80000000, 32'h00000000});
        write_reg(REG_TONE_E, {32'h00123456, 32'h01000000});
        write_reg(REG_SAMPLE_COUNT, 64'd4);
        setting_count++;
        repeat (6) send_word(1'b1);

        // zero count ends every sample; unmapped indexes must be ignored
        settle();
        write_reg(REG_SAMPLE_COUNT, 64'hFFFFFFFF_00000000);
        write_reg(REG_UNMAPPED_LO, '1);
        write_reg(REG_UNMAPPED_HI, '1);
        setting_count++;
        send_word(1'b1);
        send_word(1'b0);
        send_word(1'b1);
        send_word(1'b1);

        // longest frame, negative full-scale tone, stays mid-frame
        settle();
        write_reg(REG_SAMPLE_COUNT, 64'h00000000_FFFFFFFF);
        write_reg(REG_TONE_B, {32'h80000000, 32'hC0000000});
        setting_count++;
        repeat (4) send_word(1'b1);

        // count lowered under the running index, coefficient changed, phases kept
        settle();
        write_reg(REG_SAMPLE_COUNT, 64'd2);
        write_reg(REG_TONE_A, {32'hFFF00000, 32'h40000000});
        setting_count++;
        repeat (3) send_word(1'b1);

        // random settings, mostly small frames and realistic tones
        while (sb.ticks + idle_words < WORD_TARGET)
        begin
            settle();
            for (int j = 0; j < TONE_COUNT_DEF; j++)
                if ($urandom_range(0, 1) == 1)
                    write_reg(REG_TONE_A + 3'(j), pick_tone());   // tones at consecutive indexes
            if ($urandom_range(0, 1) == 1)
                write_reg(REG_SAMPLE_COUNT, pick_count());
            if ($urandom_range(0, 15) == 0)
                write_reg(($urandom_range(0, 1) == 1) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI,
                          {$urandom, $urandom});
            setting_count++;
            send_words($urandom_range(10, 50), 10);
        end
        settle();

        $display("covered %0d advance words and %0d idle words over %0d register settings",
                 sb.ticks, idle_words, setting_count);
        $display("checked %0d frame ends and %0d saturated samples, %0d mismatches",
                 sb.frame_ends, sb.saturated, sb.errors);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
